@@ hw/rtl/pmac_pkg.sv @@
// ----------------------------------------------------------------------------
// pmac_pkg: shared types and constants for the mod 2^116-3 polynomial MAC
//
// Beat layouts of both channels, register indexes, limb geometry and the
// widths of the working registers of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pmac_pkg;

  // Field geometry
  localparam int BLOCK_LOW_W  = 64;
  localparam int BLOCK_HIGH_W = 48;
  localparam int COUNT_W      = 4;
  localparam int MAX_BYTES    = 14;
  localparam int MSG_W        = 8 * MAX_BYTES + 1;   // data plus pad bit
  localparam int CFG_W        = 64;
  localparam int KEY_HIGH_W   = 48;
  localparam int KEY_W        = 112;
  localparam int TAG_W        = 128;

  // Arithmetic geometry: p = 2^ACC_W - FOLD
  localparam int ACC_W        = 116;
  localparam int LIMB_W       = 29;
  localparam int NUM_LIMBS    = ACC_W / LIMB_W;
  localparam int FOLD         = 3;
  localparam int MULB_W       = LIMB_W + 2;           // key limb times three
  localparam int PROD_W       = LIMB_W + MULB_W;
  localparam int Z_W          = 152;                  // column accumulator
  localparam int HI_W         = Z_W - ACC_W;

  // Configuration register indexes
  localparam int IDX_W = 2;
  localparam logic [IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [IDX_W-1:0] REG_BLIND_LOW  = 2'd2;
  localparam logic [IDX_W-1:0] REG_BLIND_HIGH = 2'd3;

  typedef struct packed {
    logic [BLOCK_LOW_W-1:0]  block_low;
    logic [BLOCK_HIGH_W-1:0] block_high;
    logic [COUNT_W-1:0]      byte_count;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W/2-1:0] tag_low;
    logic [TAG_W/2-1:0] tag_high;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/poly_mac_mod_2p116_minus_3.sv @@
// ----------------------------------------------------------------------------
// poly_mac_mod_2p116_minus_3: one-time polynomial MAC over p = 2^116 - 3
//
// Each input beat is a message block of up to 14 bytes. The padded block is
// added to the accumulator and the sum is multiplied by the key r modulo p.
// A last beat makes the block emit acc + blind (mod 2^128) and clear acc.
// ----------------------------------------------------------------------------
// A non-empty block keeps the block busy after the beat is taken: add and
// fold (ST_ADD, ST_PRE1, ST_PRE2), then a single 29 x 31 bit multiplier
// works through the 16 limb products of the 116 x 112 bit multiply (one
// product per cycle), then final reduction (ST_RED1, ST_RED2, ST_FIN). A
// last beat adds a tag write in ST_TAG; an empty last beat goes to that
// write alone, and an empty beat without last is taken and dropped while
// the block stays idle. The tag sits in an output register, so the next
// message may start while it waits; the tag write of that next message
// holds until the output register is free. The user must write the key and
// blind through the configuration port only while the block is idle; the block does not enforce it.
`default_nettype none

module poly_mac_mod_2p116_minus_3 (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_wr_en,
  input  wire [pmac_pkg::IDX_W-1:0]     cfg_index,
  input  wire [pmac_pkg::CFG_W-1:0]     cfg_data,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  pmac_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  wire                           out_ready,
  output pmac_pkg::out_item_t           out_data
);

  import pmac_pkg::*;

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ADD  = 4'd1;
  localparam logic [3:0] ST_PRE1 = 4'd2;
  localparam logic [3:0] ST_PRE2 = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_RED1 = 4'd5;
  localparam logic [3:0] ST_RED2 = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_TAG  = 4'd8;

  localparam int NPROD = NUM_LIMBS * NUM_LIMBS;
  localparam int CNT_W = $clog2(NPROD) + 1;
  localparam int SEL_W = $clog2(NUM_LIMBS);

  logic [3:0]              state;
  logic [CFG_W-1:0]        key_low;
  logic [KEY_HIGH_W-1:0]   key_high;
  logic [CFG_W-1:0]        blind_low;
  logic [CFG_W-1:0]        blind_high;
  logic [ACC_W-1:0]        acc;
  logic [MSG_W-1:0]        msg;
  logic                    last_item;
  logic [ACC_W-1:0]        opa;
  logic [Z_W-1:0]          z;
  logic [CNT_W-1:0]        cnt;
  logic [PROD_W-1:0]       prod;
  logic [SEL_W-1:0]        prod_pos;
  logic                    prod_vld;

  logic [COUNT_W-1:0]      n_eff;
  logic [8*MAX_BYTES-1:0]  data_in;
  logic [8*MAX_BYTES-1:0]  keep;
  logic [MSG_W-1:0]        msg_in;
  logic [ACC_W-1:0]        r_val;
  logic [SEL_W-1:0]        mul_i;
  logic [SEL_W-1:0]        mul_j;
  logic [SEL_W:0]          mul_k;
  logic [LIMB_W-1:0]       a_limb;
  logic [LIMB_W-1:0]       r_limb;
  logic [MULB_W-1:0]       mul_b;
  logic [PROD_W-1:0]       mul_out;
  logic [Z_W-1:0]          term;
  logic [HI_W+1:0]         h3;
  logic [Z_W-1:0]          add_a;
  logic [Z_W-1:0]          add_b;
  logic [Z_W-1:0]          sum;
  logic                    in_beat;

  assign in_ready = (state == ST_IDLE);
  assign in_beat  = in_valid && in_ready;

  // Pad and mask the incoming block
  always_comb begin
    n_eff   = (in_data.byte_count > COUNT_W'(MAX_BYTES)) ? COUNT_W'(MAX_BYTES)
                                                         : in_data.byte_count;
    data_in = {in_data.block_high, in_data.block_low};
    for (int b = 0; b < MAX_BYTES; b++) begin
      keep[8*b +: 8] = (COUNT_W'(b) < n_eff) ? 8'hff : 8'h00;
    end
    msg_in = {1'b0, data_in & keep} | (MSG_W'(1) << {n_eff, 3'b000});
  end

  // Limb product for the current count: a_i * r_j, times three past 2^116
  always_comb begin
    r_val   = {(ACC_W - KEY_W)'(0), key_high, key_low};
    mul_i   = cnt[2*SEL_W-1:SEL_W];
    mul_j   = cnt[SEL_W-1:0];
    mul_k   = {1'b0, mul_i} + {1'b0, mul_j};
    a_limb  = opa[mul_i*LIMB_W +: LIMB_W];
    r_limb  = r_val[mul_j*LIMB_W +: LIMB_W];
    mul_b   = mul_k[SEL_W] ? ({1'b0, r_limb, 1'b0} + {2'b00, r_limb})
                           : {2'b00, r_limb};
    mul_out = PROD_W'(a_limb) * PROD_W'(mul_b);
  end

  // Place the registered product at its column
  always_comb begin
    case (prod_pos)
      2'd0:    term = Z_W'(prod);
      2'd1:    term = Z_W'(prod) << LIMB_W;
      2'd2:    term = Z_W'(prod) << (2 * LIMB_W);
      default: term = Z_W'(prod) << (3 * LIMB_W);
    endcase
  end

  // Fold the bits above 2^116 by three
  assign h3 = {2'b00, z[Z_W-1:ACC_W]} + {1'b0, z[Z_W-1:ACC_W], 1'b0};

  // Shared adder operand select
  always_comb begin
    add_a = '0;
    add_b = '0;
    unique case (state) inside
      ST_ADD: begin
        add_a = Z_W'(acc);
        add_b = Z_W'(msg);
      end
      ST_PRE1, ST_PRE2, ST_RED2: begin
        add_a = Z_W'(z[ACC_W-1:0]);
        add_b = {z[ACC_W], z[ACC_W]} & Z_W'(FOLD);
      end
      ST_MUL: begin
        add_a = z;
        add_b = prod_vld ? term : '0;
      end
      ST_RED1: begin
        add_a = Z_W'(z[ACC_W-1:0]);
        add_b = Z_W'(h3);
      end
      ST_FIN: begin
        add_a = z;
        add_b = Z_W'(FOLD);
      end
      ST_TAG: begin
        add_a = Z_W'(acc);
        add_b = Z_W'({blind_high, blind_low});
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      blind_low  <= '0;
      blind_high <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_KEY_LOW:    key_low    <= cfg_data;
        REG_KEY_HIGH:   key_high   <= cfg_data[KEY_HIGH_W-1:0];
        REG_BLIND_LOW:  blind_low  <= cfg_data;
        REG_BLIND_HIGH: blind_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Working payload registers
  always_ff @(posedge clk) begin
    if (in_beat) begin
      msg       <= msg_in;
      last_item <= in_data.last;
    end
    if (state == ST_ADD || state == ST_PRE1 || state == ST_RED1 ||
        state == ST_RED2 || (state == ST_MUL && prod_vld)) begin
      z <= sum;
    end
    if (state == ST_PRE2) begin
      opa <= sum[ACC_W-1:0];
      z   <= '0;
    end
    if (state == ST_MUL && !cnt[CNT_W-1]) begin
      prod     <= mul_out;
      prod_pos <= mul_k[SEL_W-1:0];
    end
  end

  // Sequencer, accumulator and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      cnt       <= '0;
      prod_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Drop the tag beat once taken, unless a new tag replaces it
      if (out_valid && out_ready && state != ST_TAG) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (in_data.byte_count != '0) begin
              state <= ST_ADD;
            end else if (in_data.last) begin
              state <= ST_TAG;
            end
          end
        end
        ST_ADD:  state <= ST_PRE1;
        ST_PRE1: state <= ST_PRE2;
        ST_PRE2: begin
          cnt      <= '0;
          prod_vld <= 1'b0;
          state    <= ST_MUL;
        end
        ST_MUL: begin
          cnt      <= cnt + 1'b1;
          prod_vld <= !cnt[CNT_W-1];
          if (cnt[CNT_W-1]) begin
            state <= ST_RED1;
          end
        end
        ST_RED1: state <= ST_RED2;
        ST_RED2: state <= ST_FIN;
        ST_FIN: begin
          // Subtract p when z + 3 reaches 2^116
          acc   <= sum[ACC_W] ? sum[ACC_W-1:0] : z[ACC_W-1:0];
          state <= last_item ? ST_TAG : ST_IDLE;
        end
        ST_TAG: begin
          if (!out_valid || out_ready) begin
            out_data.tag_low  <= sum[TAG_W/2-1:0];
            out_data.tag_high <= sum[TAG_W-1:TAG_W/2];
            out_valid         <= 1'b1;
            acc               <= '0;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pmac_check.sv @@
// ----------------------------------------------------------------------------
// pmac_check: port-level checks for the mod 2^116-3 polynomial MAC
//
// Watches the channels of the top level and flags handshake and sequencing
// slips; attached to the top level by the bind at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module pmac_check (
  input wire                  clk,
  input wire                  rst,
  input wire                  in_valid,
  input wire                  in_ready,
  input pmac_pkg::in_item_t   in_data,
  input wire                  out_valid,
  input wire                  out_ready,
  input pmac_pkg::out_item_t  out_data
);

  import pmac_pkg::*;

  logic in_beat;
  assign in_beat = in_valid && in_ready;

  // Hold a stalled tag beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("tag beat changed or dropped while stalled");

  // Go busy after a beat that carries work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && (in_data.byte_count != '0 || in_data.last) |=> !in_ready)
    else $error("input ready right after a working beat");

  // Drop an empty non-last beat at once
  a_drop: assert property (@(posedge clk) disable iff (rst)
    in_beat && in_data.byte_count == '0 && !in_data.last |=> in_ready)
    else $error("empty beat stalled the input");

  // Emit no tag right after a non-last beat
  a_no_tag: assert property (@(posedge clk) disable iff (rst)
    in_beat && !in_data.last |=> !$rose(out_valid))
    else $error("tag appeared after a non-last beat");

endmodule

bind poly_mac_mod_2p116_minus_3 pmac_check u_pmac_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

@@ bench/poly_mac_mod_2p116_minus_3_tb.sv @@
// ----------------------------------------------------------------------------
// poly_mac_mod_2p116_minus_3_tb: self-checking bench for the mod 2^116-3 MAC
//
// Drives message blocks through the valid/ready input channel and compares
// every tag against a predictor that does the Horner step with plain wide
// arithmetic: acc = (acc + padded block) * r mod p, tag = acc + blind.
// Runs a directed pass, a sweep of extreme key and blind settings, and four
// random phases with sender gaps and receiver stalls in varying mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module poly_mac_mod_2p116_minus_3_tb;
  import pmac_pkg::*;

  localparam logic [ACC_W-1:0] MOD_P         = {ACC_W{1'b1}} - 116'd2;
  localparam int               SETTLE_CYCLES = 40;
  localparam int               BEATS_PER_PHASE = 85;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_KEY_LOW;
  logic [CFG_W-1:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Predictor state and register mirror
  logic [ACC_W-1:0] acc_model;
  logic [KEY_W-1:0] key_model;
  logic [TAG_W-1:0] blind_model;
  out_item_t        tag_q[$];

  int err_count = 0;
  int tags_checked = 0;
  int beats_sent = 0;
  int settings_used = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  poly_mac_mod_2p116_minus_3 u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Fold every bit from bit 116 up back in as times three, then one final subtract
  function automatic logic [ACC_W-1:0] reduce_mod_p(input logic [239:0] x);
    logic [239:0] v;
    v = x;
    while (v[239:ACC_W] != '0)
      v = {124'b0, v[ACC_W-1:0]} + v[239:ACC_W] * 240'd3;
    if (v[ACC_W-1:0] >= MOD_P)
      v = v - {124'b0, MOD_P};
    return v[ACC_W-1:0];
  endfunction

  // Keep the counted bytes, set the pad bit just above them
  function automatic logic [ACC_W-1:0] padded_block(input in_item_t it);
    logic [ACC_W-1:0] data;
    logic [ACC_W-1:0] mask;
    int n;
    n = (it.byte_count > MAX_BYTES) ? MAX_BYTES : int'(it.byte_count);
    data = {4'b0, it.block_high, it.block_low};
    mask = (116'd1 << (8 * n)) - 116'd1;
    return (data & mask) | (116'd1 << (8 * n));
  endfunction

  function automatic logic [ACC_W-1:0] horner_step(input logic [ACC_W-1:0] acc,
                                                   input logic [ACC_W-1:0] blk,
                                                   input logic [KEY_W-1:0] r);
    logic [239:0] sum;
    sum = {124'b0, acc} + {124'b0, blk};
    return reduce_mod_p(sum * {128'b0, r});
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(input logic [BLOCK_LOW_W-1:0] lo,
                                         input logic [BLOCK_HIGH_W-1:0] hi,
                                         input logic [COUNT_W-1:0] cnt,
                                         input logic is_last);
    in_item_t it;
    it.block_low  = lo;
    it.block_high = hi;
    it.byte_count = cnt;
    it.last       = is_last;
    return it;
  endfunction

  // Update the predictor for one accepted beat, queue a tag on last
  task automatic absorb_beat(input in_item_t it);
    out_item_t t;
    logic [TAG_W-1:0] full_tag;
    if (it.byte_count != '0)
      acc_model = horner_step(acc_model, padded_block(it), key_model);
    if (it.byte_count != '0 || it.last)
      beats_sent++;
    if (it.last) begin
      full_tag = {12'b0, acc_model} + blind_model;
      t.tag_low  = full_tag[63:0];
      t.tag_high = full_tag[127:64];
      tag_q.push_back(t);
      acc_model = '0;
    end
  endtask

  // Present one beat, hold it until taken; valid stays up unless a gap is drawn
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (send_idle_pct != 0 && $urandom_range(7) == 0)
      gap += $urandom_range(30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    absorb_beat(it);
  endtask

  // Drop valid and wait until every tag is back and the core has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (tag_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_KEY_LOW:    key_model[63:0]         = val;
      REG_KEY_HIGH:   key_model[KEY_W-1:64]   = val[KEY_HIGH_W-1:0];
      REG_BLIND_LOW:  blind_model[63:0]       = val;
      REG_BLIND_HIGH: blind_model[TAG_W-1:64] = val;
      default: ;
    endcase
  endtask

  // Load key and blind; the spare top bits of the key_high word carry junk
  task automatic program_regs(input logic [KEY_W-1:0] r, input logic [TAG_W-1:0] b);
    write_reg(REG_KEY_LOW, r[63:0]);
    write_reg(REG_KEY_HIGH, {16'($urandom_range(16'hFFFF)), r[KEY_W-1:64]});
    write_reg(REG_BLIND_LOW, b[63:0]);
    write_reg(REG_BLIND_HIGH, b[TAG_W-1:64]);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // One message of random blocks, ended by a last beat; some ignored empties mixed in
  task automatic send_message(input int nblocks);
    logic [COUNT_W-1:0] cnt;
    logic [BLOCK_LOW_W-1:0] lo;
    logic [BLOCK_HIGH_W-1:0] hi;
    int pick;
    for (int k = 0; k < nblocks; k++) begin
      if ($urandom_range(15) == 0)
        send_beat(make_item(rand64(), BLOCK_HIGH_W'(rand64()), '0, 1'b0));
      pick = $urandom_range(15);
      if (pick == 0)
        cnt = 4'd15;
      else if (pick < 4)
        cnt = COUNT_W'(MAX_BYTES);
      else
        cnt = COUNT_W'($urandom_range(MAX_BYTES, 1));
      if (k == nblocks - 1 && $urandom_range(9) == 0)
        cnt = '0;
      lo = rand64();
      hi = BLOCK_HIGH_W'(rand64());
      if ($urandom_range(7) == 0) begin
        lo = '1;
        hi = '1;
      end
      send_beat(make_item(lo, hi, cnt, k == nblocks - 1));
    end
  endtask

  // Check each tag against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (tag_q.size() == 0) begin
        $error("unexpected tag: tag_low %h tag_high %h", out_data.tag_low,
               out_data.tag_high);
        err_count++;
      end else begin
        want = tag_q.pop_front();
        tags_checked++;
        if (out_data.tag_low !== want.tag_low) begin
          $error("tag_low: expected %h, got %h", want.tag_low, out_data.tag_low);
          err_count++;
        end
        if (out_data.tag_high !== want.tag_high) begin
          $error("tag_high: expected %h, got %h", want.tag_high, out_data.tag_high);
          err_count++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Edge cases with the all-ones key and blind: an empty message, pad at each
  // byte position, junk above the count, a count of 15
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    program_regs('1, '1);
    send_beat(make_item('1, '1, '0, 1'b1));
    send_beat(make_item('0, '0, 4'd1, 1'b1));
    send_beat(make_item('1, '1, 4'd15, 1'b1));
    send_beat(make_item('1, '1, COUNT_W'(MAX_BYTES), 1'b1));
    for (int n = 1; n <= MAX_BYTES; n++)
      send_beat(make_item(rand64(), BLOCK_HIGH_W'(rand64()), COUNT_W'(n), 1'b0));
    send_beat(make_item('1, '1, '0, 1'b0));
    send_beat(make_item('0, '0, '0, 1'b1));
    settle();
  endtask

  // Extreme key and blind pairs, a few short messages each
  task automatic test_register_extremes();
    logic [KEY_W-1:0] keys[4];
    logic [TAG_W-1:0] blinds[4];
    keys[0] = '0;                 blinds[0] = '0;
    keys[1] = 112'd1;             blinds[1] = '1;
    keys[2] = {48'd0, 64'hFFFF_FFFF_FFFF_FFFF}; blinds[2] = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
    keys[3] = {48'hFFFF_FFFF_FFFF, 64'd0};      blinds[3] = {64'hFFFF_FFFF_FFFF_FFFF, 64'd0};
    for (int s = 0; s < 4; s++) begin
      program_regs(keys[s], blinds[s]);
      for (int m = 0; m < 3; m++)
        send_message($urandom_range(4, 1));
      settle();
    end
  endtask

  // Random messages under one idling mix, fresh random key and blind
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    program_regs(KEY_W'({rand64(), rand64()}), {rand64(), rand64()});
    start = beats_sent;
    while (beats_sent - start < BEATS_PER_PHASE) begin
      if ($urandom_range(7) == 0)
        send_message($urandom_range(20, 8));
      else
        send_message($urandom_range(5, 1));
    end
    settle();
  endtask

  initial begin
    acc_model   = '0;
    key_model   = '0;
    blind_model = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(61, 0);
    test_random_traffic(0, 61);
    test_random_traffic(37, 37);
    $display("Sent %0d counted beats, checked %0d tags over %0d key/blind settings,",
             beats_sent, tags_checked, settings_used);
    $display("with sender gaps and receiver stalls mixed in the later phases.");
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/pmac_pkg.sv
hw/rtl/poly_mac_mod_2p116_minus_3.sv
hw/rtl/pmac_check.sv
bench/poly_mac_mod_2p116_minus_3_tb.sv
